/* sv/terminated_request_deframer_top_assert.svh */
// Assertion macros shared by the deframer modules.
// Both expect clk_i and rst_ni in the enclosing module.
`ifndef TERMINATED_REQUEST_DEFRAMER_TOP_ASSERT_SVH
`define TERMINATED_REQUEST_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication.
`define TRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

/* sv/trd_pkg.sv */
package trd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RunW   = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] TermValueReset = 8'hFF;
  localparam logic [RunW-1:0]  TermRunReset   = 4'd2;
  localparam logic [ByteW-1:0] SepByte        = 8'h00;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TERM_VALUE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TERM_RUN   = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_OPCODE  = 3'd0,
    KIND_COUNT   = 3'd1,
    KIND_DATA    = 3'd2,
    KIND_SEP     = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] pnum;
    logic             closed;
    logic             done;
    logic [ByteW-1:0] fop;
    logic [ByteW-1:0] delivered;
  } result_t;

endpackage

/* sv/trd_cfg.sv */
module trd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [trd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [trd_pkg::ByteW-1:0]  cfg_wdata_i,
  output logic [trd_pkg::ByteW-1:0]  term_value_o,
  output logic [trd_pkg::RunW-1:0]   term_run_o
);
  import trd_pkg::*;

  logic [ByteW-1:0] term_value_q;
  logic [RunW-1:0]  term_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_value_q <= TermValueReset;
      term_run_q   <= TermRunReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TERM_VALUE: term_value_q <= cfg_wdata_i;
        CFG_TERM_RUN:   term_run_q   <= cfg_wdata_i[RunW-1:0];
        default:        term_run_q   <= term_run_q;
      endcase
    end
  end

  assign term_value_o = term_value_q;
  assign term_run_o   = term_run_q;

endmodule

/* sv/trd_core.sv */
`include "terminated_request_deframer_top_assert.svh"

module trd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [trd_pkg::ByteW-1:0] byte_i,
  input  logic [trd_pkg::ByteW-1:0] term_value_i,
  input  logic [trd_pkg::RunW-1:0]  term_run_i,
  output trd_pkg::result_t          result_o
);
  import trd_pkg::*;

  localparam logic [1:0] PHASE_OPCODE = 2'd0;
  localparam logic [1:0] PHASE_COUNT  = 2'd1;
  localparam logic [1:0] PHASE_PARAMS = 2'd2;
  localparam logic [RunW-1:0] RunMax  = {RunW{1'b1}};

  logic [RunW-1:0]  run_q, run_d;
  logic [1:0]       phase_q, phase_d;
  logic [ByteW-1:0] opcode_q, opcode_d;
  logic [ByteW-1:0] declared_q, declared_d;
  logic [ByteW-1:0] done_q, done_d;
  logic             open_q, open_d;
  result_t          res;

  always_comb begin
    run_d      = run_q;
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    declared_d = declared_q;
    done_d     = done_q;
    open_d     = open_q;

    res           = '0;
    res.kind      = KIND_IGNORED;
    res.value     = byte_i;

    if (byte_i == term_value_i) begin
      if (run_q != RunMax) begin
        run_d = run_q + 1'b1;
      end
    end else begin
      run_d = '0;
    end

    // The unused phase code behaves as the parameter phase.
    priority if (phase_q == PHASE_OPCODE) begin
      res.kind = KIND_OPCODE;
      opcode_d = byte_i;
      phase_d  = PHASE_COUNT;
    end else if (phase_q == PHASE_COUNT) begin
      res.kind   = KIND_COUNT;
      declared_d = byte_i;
      phase_d    = PHASE_PARAMS;
    end else if (open_q) begin
      res.pnum = done_q;
      if (byte_i == SepByte) begin
        res.kind   = KIND_SEP;
        res.closed = 1'b1;
        open_d     = 1'b0;
        done_d     = done_q + 1'b1;
      end else begin
        res.kind = KIND_DATA;
      end
    end else if (done_q < declared_q) begin
      res.pnum = done_q;
      if (byte_i == SepByte) begin
        res.kind   = KIND_SEP;
        res.closed = 1'b1;
        done_d     = done_q + 1'b1;
      end else begin
        res.kind = KIND_DATA;
        open_d   = 1'b1;
      end
    end else begin
      res.kind = KIND_IGNORED;
    end

    if ((term_run_i != '0) && (run_d == term_run_i)) begin
      res.done = 1'b1;
      // A parameter still open is closed by the byte that ends the frame.
      if (open_d) begin
        res.closed = 1'b1;
        res.pnum   = done_d;
        done_d     = done_d + 1'b1;
      end
      res.fop       = opcode_d;
      res.delivered = done_d;
      run_d         = '0;
      phase_d       = PHASE_OPCODE;
      opcode_d      = '0;
      declared_d    = '0;
      done_d        = '0;
      open_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      phase_q    <= PHASE_OPCODE;
      opcode_q   <= '0;
      declared_q <= '0;
      done_q     <= '0;
      open_q     <= 1'b0;
    end else if (step_i) begin
      run_q      <= run_d;
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      declared_q <= declared_d;
      done_q     <= done_d;
      open_q     <= open_d;
    end
  end

  assign result_o = res;

  `TRD_ASSERT_NOW(a_done_le_declared, 1'b1, done_q <= declared_q)
  `TRD_ASSERT_NOW(a_open_in_params, open_q,
                  (phase_q != PHASE_OPCODE) && (phase_q != PHASE_COUNT) && (done_q < declared_q))
  `TRD_ASSERT_NEXT(a_frame_end_clears, step_i && res.done,
                   (run_q == '0) && (phase_q == PHASE_OPCODE) && !open_q)

endmodule

/* sv/terminated_request_deframer_top.sv */
// Request deframer: classifies a received byte stream, one byte per beat.
// Input channel: in_valid_i / in_ready_o with rx_byte_i. Output channel:
// out_valid_o / out_ready_i with one result per input byte (kind, value,
// parameter number, close and frame-end flags, opcode and parameter count).
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0: terminator value, 1: terminator run length); write only while idle.
// A byte accepted into the input register is classified against the frame
// state as it moves to the result register, and its result is shown from then
// on. Throughput is one byte per cycle while the receiver does not stall; the
// frame state in trd_core is updated as each byte advances.
// A stalled receiver holds the result register; the input register still
// accepts one more beat, after which in_ready_o drops until the result moves.
// Reset clears both pipeline stages and the frame state, and loads the
// terminator value 0xFF and run length 2.
`include "terminated_request_deframer_top_assert.svh"

module terminated_request_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [trd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [trd_pkg::KindW-1:0]   byte_kind_o,
  output logic [trd_pkg::ByteW-1:0]   byte_value_o,
  output logic [trd_pkg::ByteW-1:0]   param_number_o,
  output logic                        param_closed_o,
  output logic                        frame_done_o,
  output logic [trd_pkg::ByteW-1:0]   frame_opcode_o,
  output logic [trd_pkg::ByteW-1:0]   params_delivered_o,
  input  logic                        cfg_we_i,
  input  logic [trd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [trd_pkg::ByteW-1:0]   cfg_wdata_i
);
  import trd_pkg::*;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          core_res;
  logic             s1_adv;
  logic             in_fire;
  logic [ByteW-1:0] term_value;
  logic [RunW-1:0]  term_run;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  trd_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .term_value_o (term_value),
    .term_run_o   (term_run)
  );

  trd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_adv),
    .byte_i       (s1_byte_q),
    .term_value_i (term_value),
    .term_run_i   (term_run),
    .result_o     (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_adv) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign byte_kind_o        = out_q.kind;
  assign byte_value_o       = out_q.value;
  assign param_number_o     = out_q.pnum;
  assign param_closed_o     = out_q.closed;
  assign frame_done_o       = out_q.done;
  assign frame_opcode_o     = out_q.fop;
  assign params_delivered_o = out_q.delivered;

  `TRD_ASSERT_NOW(a_sep_closes, out_valid_q && (out_q.kind == KIND_SEP), out_q.closed)
  `TRD_ASSERT_NOW(a_no_param_kinds,
                  out_valid_q && ((out_q.kind == KIND_OPCODE) || (out_q.kind == KIND_COUNT) ||
                                  (out_q.kind == KIND_IGNORED)),
                  !out_q.closed && (out_q.pnum == '0))
  `TRD_ASSERT_NOW(a_summary_only_at_end, out_valid_q && !out_q.done,
                  (out_q.fop == '0) && (out_q.delivered == '0))

endmodule

/* test/terminated_request_deframer_top_tb.sv */
`timescale 1ns / 1ps

module terminated_request_deframer_top_tb;
  import trd_pkg::*;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_COUNT,
    PH_PARAMS
  } phase_e;

  typedef struct {
    bit               is_cfg;
    logic [ByteW-1:0] rx;
    bit               has_exp;
    result_t          exp;
    logic [ByteW-1:0] cfg_value;
    logic [RunW-1:0]  cfg_run;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [KindW-1:0]    byte_kind_o;
  logic [ByteW-1:0]    byte_value_o;
  logic [ByteW-1:0]    param_number_o;
  logic                param_closed_o;
  logic                frame_done_o;
  logic [ByteW-1:0]    frame_opcode_o;
  logic [ByteW-1:0]    params_delivered_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ByteW-1:0]    cfg_wdata_i;

  // Shadow of the block's registers and frame state.
  logic [ByteW-1:0] term_value_cfg = TermValueReset;
  logic [RunW-1:0]  term_run_cfg   = TermRunReset;
  logic [RunW-1:0]  run_seen;
  phase_e           phase;
  logic [ByteW-1:0] op_held;
  logic [ByteW-1:0] count_declared;
  logic [ByteW-1:0] params_made;
  logic             param_is_open;

  result_t     pending_classes[$];
  stim_row_t   directed_rows[$];
  stim_row_t   directed_checks[$];
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 81;
  bit          hold_request = 1'b0;

  terminated_request_deframer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .byte_kind_o       (byte_kind_o),
    .byte_value_o      (byte_value_o),
    .param_number_o    (param_number_o),
    .param_closed_o    (param_closed_o),
    .frame_done_o      (frame_done_o),
    .frame_opcode_o    (frame_opcode_o),
    .params_delivered_o(params_delivered_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_frame_state();
    run_seen       = '0;
    phase          = PH_OPCODE;
    op_held        = '0;
    count_declared = '0;
    params_made    = '0;
    param_is_open  = 1'b0;
  endtask

  task automatic classify_byte(input logic [ByteW-1:0] b, output result_t r);
    r       = '0;
    r.value = b;
    if (b == term_value_cfg) begin
      if (run_seen != 4'd15) run_seen++;
    end else begin
      run_seen = '0;
    end
    case (phase)
      PH_OPCODE: begin
        r.kind  = KIND_OPCODE;
        op_held = b;
        phase   = PH_COUNT;
      end
      PH_COUNT: begin
        r.kind         = KIND_COUNT;
        count_declared = b;
        phase          = PH_PARAMS;
      end
      default: begin
        // A new parameter may only open while the declared count is not reached.
        if (param_is_open || params_made < count_declared) begin
          r.pnum = params_made;
          if (b == SepByte) begin
            r.kind        = KIND_SEP;
            r.closed      = 1'b1;
            param_is_open = 1'b0;
            params_made++;
          end else begin
            r.kind        = KIND_DATA;
            param_is_open = 1'b1;
          end
        end else begin
          r.kind = KIND_IGNORED;
        end
      end
    endcase
    if (term_run_cfg != '0 && run_seen == term_run_cfg) begin
      r.done = 1'b1;
      if (param_is_open) begin
        r.closed = 1'b1;
        r.pnum   = params_made;
        params_made++;
      end
      r.fop       = op_held;
      r.delivered = params_made;
      clear_frame_state();
    end
  endtask

  task automatic compare_field(input string name, input logic [ByteW-1:0] want,
                               input logic [ByteW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Predict on every accepted input beat, check on every accepted output beat.
  always @(posedge clk_i) begin
    result_t   predicted;
    result_t   want;
    stim_row_t row;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        classify_byte(rx_byte_i, predicted);
        if (directed_checks.size() != 0) begin
          row = directed_checks.pop_front();
          if (row.has_exp) predicted = row.exp;
        end
        pending_classes.push_back(predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_classes.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual kind %0d value %0h",
                   $time, byte_kind_o, byte_value_o);
        end else begin
          want = pending_classes.pop_front();
          compare_field("byte_kind", 8'(want.kind), 8'(byte_kind_o));
          compare_field("byte_value", want.value, byte_value_o);
          compare_field("param_number", want.pnum, param_number_o);
          compare_field("param_closed", 8'(want.closed), 8'(param_closed_o));
          compare_field("frame_done", 8'(want.done), 8'(frame_done_o));
          compare_field("frame_opcode", want.fop, frame_opcode_o);
          compare_field("params_delivered", want.delivered, params_delivered_o);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
        out_ready_i  <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic result_t mk_result(kind_e kind, logic [ByteW-1:0] value,
                                        logic [ByteW-1:0] pnum, logic closed, logic done,
                                        logic [ByteW-1:0] fop, logic [ByteW-1:0] delivered);
    result_t r;
    r.kind      = kind;
    r.value     = value;
    r.pnum      = pnum;
    r.closed    = closed;
    r.done      = done;
    r.fop       = fop;
    r.delivered = delivered;
    return r;
  endfunction

  task automatic add_byte(input logic [ByteW-1:0] b);
    stim_row_t row;
    row        = '{default: '0};
    row.rx     = b;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [ByteW-1:0] b, input result_t exp);
    stim_row_t row;
    row         = '{default: '0};
    row.rx      = b;
    row.has_exp = 1'b1;
    row.exp     = exp;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [ByteW-1:0] value, input logic [RunW-1:0] run);
    stim_row_t row;
    row           = '{default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    row.cfg_run   = run;
    directed_rows.push_back(row);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_classes.size() != 0) @(posedge clk_i);
  endtask

  // Both registers are written on back-to-back edges; the block must be idle.
  task automatic set_config(input logic [ByteW-1:0] value, input logic [RunW-1:0] run);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TERM_VALUE;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_index_i <= CFG_TERM_RUN;
    cfg_wdata_i <= ByteW'(run);
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    term_value_cfg = value;
    term_run_cfg   = run;
  endtask

  function automatic logic [ByteW-1:0] content_byte();
    logic [ByteW-1:0] b;
    if ($urandom_range(15) == 0) return term_value_cfg;
    b = 8'($urandom_range(1, 255));
    if (b == term_value_cfg) b = b ^ 8'h80;
    return b;
  endfunction

  // Mostly well-formed frames with random content; some noise and broken runs.
  task automatic send_frame();
    int unsigned nparams;
    int unsigned n_term;
    logic [ByteW-1:0] declared;
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      return;
    end
    send_byte(8'($urandom));
    declared = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    send_byte(declared);
    nparams = $urandom_range(0, 6);
    for (int i = 0; i < nparams; i++) begin
      repeat ($urandom_range(0, 4)) send_byte(content_byte());
      // The last parameter is sometimes left open for the frame end to close.
      if (i + 1 < nparams || $urandom_range(3) != 0) send_byte(SepByte);
    end
    if (term_run_cfg == '0) n_term = 2;
    else if ($urandom_range(7) == 0) n_term = $urandom_range(0, term_run_cfg - 1);
    else n_term = term_run_cfg;
    repeat (n_term) send_byte(term_value_cfg);
  endtask

  initial begin
    logic [ByteW-1:0]  seg_value[6] = '{8'hFF, 8'h00, 8'h5A, 8'h5A, 8'hFF, 8'hC3};
    logic [RunW-1:0]   seg_run[6]   = '{4'd2, 4'd1, 4'd0, 4'd15, 4'd1, 4'd7};
    int unsigned       seg_items[6] = '{270, 270, 120, 300, 300, 300};
    int unsigned       target;
    stim_row_t         row;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    clear_frame_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Frame with a data parameter, an empty parameter and ignored bytes.
    add_checked(8'h07, mk_result(KIND_OPCODE, 8'h07, 0, 0, 0, 0, 0));
    add_checked(8'h02, mk_result(KIND_COUNT, 8'h02, 0, 0, 0, 0, 0));
    add_checked(8'h41, mk_result(KIND_DATA, 8'h41, 0, 0, 0, 0, 0));
    add_checked(8'h00, mk_result(KIND_SEP, 8'h00, 0, 1, 0, 0, 0));
    add_checked(8'h00, mk_result(KIND_SEP, 8'h00, 1, 1, 0, 0, 0));
    add_checked(8'h55, mk_result(KIND_IGNORED, 8'h55, 0, 0, 0, 0, 0));
    add_checked(8'hFF, mk_result(KIND_IGNORED, 8'hFF, 0, 0, 0, 0, 0));
    add_checked(8'hFF, mk_result(KIND_IGNORED, 8'hFF, 0, 0, 1, 8'h07, 8'd2));
    // An open parameter is closed by the frame end.
    add_checked(8'h00, mk_result(KIND_OPCODE, 8'h00, 0, 0, 0, 0, 0));
    add_checked(8'hFF, mk_result(KIND_COUNT, 8'hFF, 0, 0, 0, 0, 0));
    add_checked(8'hFF, mk_result(KIND_DATA, 8'hFF, 0, 1, 1, 8'h00, 8'd1));
    // NUL terminator with a run of one: a frame on its opcode alone, and a NUL
    // that separates and ends the frame at once.
    add_cfg(8'h00, 4'd1);
    add_checked(8'h00, mk_result(KIND_OPCODE, 8'h00, 0, 0, 1, 8'h00, 8'd0));
    add_checked(8'h09, mk_result(KIND_OPCODE, 8'h09, 0, 0, 0, 0, 0));
    add_checked(8'h03, mk_result(KIND_COUNT, 8'h03, 0, 0, 0, 0, 0));
    add_checked(8'h11, mk_result(KIND_DATA, 8'h11, 0, 0, 0, 0, 0));
    add_checked(8'h00, mk_result(KIND_SEP, 8'h00, 0, 1, 1, 8'h09, 8'd1));
    // With a run length of zero no frame ends.
    add_cfg(8'hFF, 4'd0);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_cfg(8'hFF, 4'd1);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h00);
    add_byte(8'h33);
    add_byte(8'hFF);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain_results();
        set_config(row.cfg_value, row.cfg_run);
      end else begin
        directed_checks.push_back(row);
        send_byte(row.rx);
      end
    end

    for (int s = 0; s < 6; s++) begin
      drain_results();
      set_config(seg_value[s], seg_run[s]);
      send_idle_pct = (s < 2) ? 13 : (s < 4) ? 81 : 0;
      recv_idle_pct = (s < 2) ? 81 : (s < 4) ? 13 : 0;
      if (s == 4) hold_request = 1'b1;
      // A leading terminator byte shows a run counter saturated earlier.
      send_byte(term_value_cfg);
      target = items_sent + seg_items[s];
      while (items_sent < target) send_frame();
      repeat (17) send_byte(term_value_cfg);
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
